// ===== sv/dlc_pkg.sv =====
// ----------------------------------------------------------------------------
// dlc_pkg: shared types and constants of the dusk light controller
// Item structs, configuration register map and reset values.
// ----------------------------------------------------------------------------
package dlc_pkg;

    // debounce history length and minute counter width
    localparam int DEBOUNCE_LEN = 8;
    localparam int MINUTE_BITS  = 32;

    // configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // configuration reset values
    localparam logic [7:0]  LUX_THRESHOLD_RST    = 8'd123;
    localparam logic [15:0] TICKS_PER_MINUTE_RST = 16'd30000;
    localparam logic [7:0]  CHECK_INTERVAL_RST   = 8'd2;
    localparam logic [3:0]  CONFIRM_COUNT_RST    = 4'd8;
    localparam logic [15:0] MIN_ON_MINUTES_RST   = 16'd60;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LUX_THRESHOLD    = 3'd0,
        CFG_TICKS_PER_MINUTE = 3'd1,
        CFG_CHECK_INTERVAL   = 3'd2,
        CFG_CONFIRM_COUNT    = 3'd3,
        CFG_MIN_ON_MINUTES   = 3'd4
    } cfg_index_t;

    // one tick item
    typedef struct packed {
        logic       button_raw;
        logic [7:0] light_level;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic       lamp_on;
        logic       manual_mode;
        logic [3:0] confirm_level;
    } out_item_t;

    // configuration register set
    typedef struct packed {
        logic [7:0]  lux_threshold;
        logic [15:0] ticks_per_minute;
        logic [7:0]  check_interval;
        logic [3:0]  confirm_count;
        logic [15:0] min_on_minutes;
    } cfg_t;

endpackage

// ===== sv/dlc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dlc_cfg_regs: configuration register file
// Holds the five settings, written one at a time through the config port.
// ----------------------------------------------------------------------------
module dlc_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dlc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dlc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output dlc_pkg::cfg_t                     cfg
);

    dlc_pkg::cfg_t cfg_reg;
    dlc_pkg::cfg_t cfg_next;

    // writes are always taken
    assign cfg_ready = 1'b1;

    // decode the register index, unknown indexes leave everything as is
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                dlc_pkg::CFG_LUX_THRESHOLD:    cfg_next.lux_threshold    = cfg_data[7:0];
                dlc_pkg::CFG_TICKS_PER_MINUTE: cfg_next.ticks_per_minute = cfg_data[15:0];
                dlc_pkg::CFG_CHECK_INTERVAL:   cfg_next.check_interval   = cfg_data[7:0];
                dlc_pkg::CFG_CONFIRM_COUNT:    cfg_next.confirm_count    = cfg_data[3:0];
                dlc_pkg::CFG_MIN_ON_MINUTES:   cfg_next.min_on_minutes   = cfg_data[15:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lux_threshold    <= dlc_pkg::LUX_THRESHOLD_RST;
            cfg_reg.ticks_per_minute <= dlc_pkg::TICKS_PER_MINUTE_RST;
            cfg_reg.check_interval   <= dlc_pkg::CHECK_INTERVAL_RST;
            cfg_reg.confirm_count    <= dlc_pkg::CONFIRM_COUNT_RST;
            cfg_reg.min_on_minutes   <= dlc_pkg::MIN_ON_MINUTES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/dusk_light_controller_top.sv =====
// ----------------------------------------------------------------------------
// dusk_light_controller_top: automatic dusk lamp with manual override
// Results: a tick item's result is registered in the output register once that register is free.
// Throughput: one tick item per cycle, from an input register through the
// single-pass update into an output register; stall back-pressure only.
// Reset: asynchronous, active low; all counters, history and lamp clear,
// configuration returns to its defaults, no clearing pass.
// ----------------------------------------------------------------------------
module dusk_light_controller_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // tick items
    input  logic                              in_valid,
    output logic                              in_stall,
    input  dlc_pkg::in_item_t                 in_data,
    // result items
    output logic                              out_valid,
    input  logic                              out_stall,
    output dlc_pkg::out_item_t                out_data,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dlc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dlc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int MW = dlc_pkg::MINUTE_BITS;
    localparam int DL = dlc_pkg::DEBOUNCE_LEN;

    dlc_pkg::cfg_t cfg;

    // pipeline registers
    logic               s1_valid_reg;
    dlc_pkg::in_item_t  s1_data_reg;
    logic               out_valid_reg;
    dlc_pkg::out_item_t out_data_reg;

    // controller state
    logic [DL-1:0] hist_reg,        hist_next;
    logic [15:0]   tick_reg,        tick_next;
    logic [MW-1:0] minute_reg,      minute_next;
    logic [MW-1:0] last_check_reg,  last_check_next;
    logic [3:0]    agree_reg,       agree_next;
    logic          lamp_reg,        lamp_next;
    logic [MW-1:0] last_change_reg, last_change_next;

    logic               out_free;
    logic               take_item;
    logic [16:0]        tick_inc;
    logic               manual;
    logic               dark;
    logic               due;
    logic               agrees;
    logic [3:0]         agree_inc;
    logic               may_toggle;
    logic               lamp_out;
    dlc_pkg::out_item_t result;

    dlc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // flow control: the input register moves on when the output register frees up
    assign out_free  = !out_valid_reg || !out_stall;
    assign take_item = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;

    // tick update
    always_comb
    begin
        hist_next        = {hist_reg[DL-2:0], s1_data_reg.button_raw};
        tick_inc         = {1'b0, tick_reg} + 17'd1;
        tick_next        = tick_inc[15:0];
        minute_next      = minute_reg;
        last_check_next  = last_check_reg;
        agree_next       = agree_reg;
        lamp_next        = lamp_reg;
        last_change_next = last_change_reg;
        agrees           = 1'b0;
        agree_inc        = agree_reg;
        may_toggle       = 1'b0;
        due              = 1'b0;

        // minute counting
        if (tick_inc >= {1'b0, cfg.ticks_per_minute})
        begin
            tick_next   = 16'd0;
            minute_next = minute_reg + MW'(1);
        end

        manual = (hist_next == {DL{1'b1}});
        dark   = (s1_data_reg.light_level < cfg.lux_threshold);

        if (manual)
        begin
            // button held: lamp follows darkness, automatic lamp and change time drop
            lamp_out         = dark;
            lamp_next        = 1'b0;
            last_change_next = '0;
        end
        else
        begin
            due = ((minute_next - last_check_reg) >= MW'(cfg.check_interval));
            if (due)
            begin
                last_check_next = minute_next;
                agrees = lamp_reg ? !dark : dark;
                if (agrees)
                begin
                    // saturating count toward confirmation
                    agree_inc  = (agree_reg < cfg.confirm_count) ? agree_reg + 4'd1
                                                                 : agree_reg;
                    agree_next = agree_inc;
                    if (agree_inc >= cfg.confirm_count)
                    begin
                        may_toggle = !lamp_reg ||
                            ((minute_next - last_change_reg) > MW'(cfg.min_on_minutes));
                        if (may_toggle)
                        begin
                            lamp_next        = !lamp_reg;
                            agree_next       = 4'd0;
                            last_change_next = minute_next;
                        end
                    end
                end
                else if (agree_reg != 4'd0)
                begin
                    agree_next = agree_reg - 4'd1;
                end
            end
            lamp_out = lamp_next;
        end

        result.lamp_on       = lamp_out;
        result.manual_mode   = manual;
        result.confirm_level = agree_next;
    end

    // input register and output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_data_reg <= in_data;
        end
        if (take_item)
        begin
            out_data_reg <= result;
        end
    end

    // controller state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg        <= '0;
            tick_reg        <= '0;
            minute_reg      <= '0;
            last_check_reg  <= '0;
            agree_reg       <= '0;
            lamp_reg        <= 1'b0;
            last_change_reg <= '0;
        end
        else if (take_item)
        begin
            hist_reg        <= hist_next;
            tick_reg        <= tick_next;
            minute_reg      <= minute_next;
            last_check_reg  <= last_check_next;
            agree_reg       <= agree_next;
            lamp_reg        <= lamp_next;
            last_change_reg <= last_change_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // stall on the input only while the input register holds an item
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with an empty input register");

    // manual handling leaves the automatic lamp off
    a_manual_clears_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        take_item && manual |=> !lamp_reg && (last_change_reg == '0))
        else $error("manual tick did not clear automatic lamp state");

    // an automatic lamp toggle always restarts the agreement counter
    a_toggle_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        take_item && !manual && (lamp_next != lamp_reg) |=> (agree_reg == 4'd0))
        else $error("lamp toggled without clearing the agreement counter");

    // tick counter stays inside the minute after a tick
    a_tick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        take_item && (cfg.ticks_per_minute != 16'd0)
        |=> (tick_reg < $past(cfg.ticks_per_minute)))
        else $error("tick counter beyond ticks per minute");

endmodule
